### rtl/pngu_pkg.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Payload types, filter codes and register indexes shared by the unfilter RTL.
// ----------------------------------------------------------------------------
package pngu_pkg;

   localparam int BYTE_W  = 8;
   localparam int BPP_W   = 3;
   localparam int ROWB_W  = 14;
   localparam int KIND_W  = 3;
   localparam int SLOT_W  = 2;
   localparam int CSR_IDX_W = 1;

   // filter type codes; anything above PAETH is folded to BAD
   localparam logic [KIND_W-1:0] FILT_NONE  = 3'd0;
   localparam logic [KIND_W-1:0] FILT_SUB   = 3'd1;
   localparam logic [KIND_W-1:0] FILT_UP    = 3'd2;
   localparam logic [KIND_W-1:0] FILT_AVG   = 3'd3;
   localparam logic [KIND_W-1:0] FILT_PAETH = 3'd4;
   localparam logic [KIND_W-1:0] FILT_BAD   = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_BPP       = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES = 1'd1;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              new_pass;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] pixel_byte;
      logic              row_last;
      logic              bad_filter;
   } rsp_payload_type;

   function automatic logic [BYTE_W-1:0] paeth_pred(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b,
                                                    input logic [BYTE_W-1:0] c);
      logic signed [BYTE_W+2:0] sa;
      logic signed [BYTE_W+2:0] sb;
      logic signed [BYTE_W+2:0] sc;
      logic signed [BYTE_W+2:0] da;
      logic signed [BYTE_W+2:0] db;
      logic signed [BYTE_W+2:0] dc;
      logic [BYTE_W+2:0]        pa;
      logic [BYTE_W+2:0]        pb;
      logic [BYTE_W+2:0]        pc;
      logic [BYTE_W-1:0]        res;
      sa = $signed({3'b000, a});
      sb = $signed({3'b000, b});
      sc = $signed({3'b000, c});
      da = sb - sc;
      db = sa - sc;
      dc = sa + sb - sc - sc;
      pa = (da < 0) ? $unsigned(-da) : $unsigned(da);
      pb = (db < 0) ? $unsigned(-db) : $unsigned(db);
      pc = (dc < 0) ? $unsigned(-dc) : $unsigned(dc);
      if ((pa <= pb) && (pa <= pc)) begin
         res = a;
      end else if (pb <= pc) begin
         res = b;
      end else begin
         res = c;
      end
      return res;
   endfunction

endpackage

### rtl/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// PNG scanline unfilter
// Rebuilds filtered scanline bytes (None/Sub/Up/Average/Paeth) from the
// inflated stream, keeping the previous row in an on-chip memory.
// ----------------------------------------------------------------------------
// Takes one item per clock in both directions while results are taken. An
// item is a byte of the inflated stream: the filter-type byte that opens each
// row, then row_bytes data bytes. Each data byte gives one result through the
// compute stage and the result register; a filter byte gives none unless its
// type is above 4, in which case an error result is sent and the row passes
// through unfiltered. The previous row is read from a single-port-read memory
// as an item is accepted and rewritten as its byte leaves the compute stage,
// so the filter byte between two rows keeps a short row's read clear of its
// own write. Set new_pass with the filter byte of the first row of an image
// or interlace pass; reads of the previous row beyond the longest row written
// since reset are undefined. Write the registers only while the block is idle.
// ----------------------------------------------------------------------------
module png_scanline_unfilter
   import pngu_pkg::*;
#(
   parameter int MAX_ROW_BYTES = 8192
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ROWB_W-1:0]    csr_wdata
);

   localparam int AW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int LW0 = $clog2(MAX_ROW_BYTES + 1);
   localparam int CW  = ((LW0 > ROWB_W) ? LW0 : ROWB_W) + 1;
   localparam logic [CW-1:0] MAX_LEN = CW'(MAX_ROW_BYTES);

   // config
   logic [BPP_W-1:0]  bpp_ff;
   logic [ROWB_W-1:0] row_bytes_ff;

   // row tracking, updated at accept
   logic              await_ff, await_in;
   logic              first_ff, first_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [SLOT_W-1:0] mod3_ff, mod3_in;
   logic [KIND_W-1:0] kind_ff, kind_in;

   // compute stage
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_filter_ff;
   logic [KIND_W-1:0] s1_kind_ff;
   logic              s1_first_ff;
   logic              s1_last_ff;
   logic [SLOT_W-1:0] s1_slot_ff;
   logic [AW-1:0]     s1_idx_ff;

   logic [BYTE_W-1:0] prior_mem [MAX_ROW_BYTES];
   logic [BYTE_W-1:0] prior_rd_ff;

   logic [BYTE_W-1:0] left_ff  [4];
   logic [BYTE_W-1:0] aleft_ff [4];

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff;

   logic              accept;
   logic              s1_has_out;
   logic              s1_adv;
   logic              load_rsp;
   logic [SLOT_W-1:0] bpp_last;
   logic [SLOT_W-1:0] slot_cur;
   logic [CW-1:0]     eff_len;
   logic              is_last;
   logic [KIND_W-1:0] new_kind;
   logic [BYTE_W-1:0] op_a, op_b, op_c, pred, rec;
   logic [BYTE_W:0]   avg_sum;
   rsp_payload_type   rsp_next;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff       <= BPP_W'(1);
         row_bytes_ff <= ROWB_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BPP:       bpp_ff       <= csr_wdata[BPP_W-1:0];
            CSR_ROW_BYTES: row_bytes_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake
   assign s1_has_out = !s1_filter_ff || (s1_kind_ff == FILT_BAD);
   assign s1_adv     = s1_valid_ff && (!s1_has_out || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_adv;
   assign accept     = req_valid && req_ready;
   assign load_rsp   = s1_adv && s1_has_out;

   // effective bytes per pixel as last slot, effective row length
   always_comb begin
      if (bpp_ff == BPP_W'(0)) begin
         bpp_last = SLOT_W'(0);
      end else if (bpp_ff > BPP_W'(4)) begin
         bpp_last = SLOT_W'(3);
      end else begin
         bpp_last = SLOT_W'(bpp_ff - BPP_W'(1));
      end
      if (row_bytes_ff == ROWB_W'(0)) begin
         eff_len = CW'(1);
      end else if (CW'(row_bytes_ff) > MAX_LEN) begin
         eff_len = MAX_LEN;
      end else begin
         eff_len = CW'(row_bytes_ff);
      end
   end

   // neighbour slot is the row position modulo the current pixel size
   always_comb begin
      case (bpp_last)
         SLOT_W'(0): slot_cur = SLOT_W'(0);
         SLOT_W'(1): slot_cur = SLOT_W'(pos_ff[0]);
         SLOT_W'(2): slot_cur = mod3_ff;
         default:    slot_cur = SLOT_W'(pos_ff);
      endcase
   end

   assign is_last  = (CW'(pos_ff) + CW'(1)) >= eff_len;
   assign new_kind = (req_payload.data_byte > BYTE_W'(FILT_PAETH)) ? FILT_BAD
                                                          : req_payload.data_byte[KIND_W-1:0];

   always_comb begin
      await_in = await_ff;
      first_in = first_ff;
      pos_in   = pos_ff;
      mod3_in  = mod3_ff;
      kind_in  = kind_ff;
      if (accept) begin
         if (await_ff) begin
            kind_in  = new_kind;
            first_in = first_ff | req_payload.new_pass;
            pos_in   = '0;
            mod3_in  = '0;
            await_in = 1'b0;
         end else if (is_last) begin
            await_in = 1'b1;
            first_in = 1'b0;
         end else begin
            pos_in  = pos_ff + AW'(1);
            mod3_in = (mod3_ff == SLOT_W'(2)) ? SLOT_W'(0) : mod3_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         await_ff <= 1'b1;
         first_ff <= 1'b1;
         pos_ff   <= '0;
         mod3_ff  <= '0;
         kind_ff  <= FILT_NONE;
      end else begin
         await_ff <= await_in;
         first_ff <= first_in;
         pos_ff   <= pos_in;
         mod3_ff  <= mod3_in;
         kind_ff  <= kind_in;
      end
   end

   assign s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff   <= req_payload.data_byte;
         s1_filter_ff <= await_ff;
         s1_kind_ff   <= await_ff ? new_kind : kind_ff;
         s1_first_ff  <= first_ff;
         s1_last_ff   <= is_last;
         s1_slot_ff   <= slot_cur;
         s1_idx_ff    <= pos_ff;
      end
   end

   // prior row: read on accept, write back once the byte is rebuilt
   always_ff @(posedge clock) begin
      if (accept && !await_ff) begin
         prior_rd_ff <= prior_mem[pos_ff];
      end
      if (s1_adv && !s1_filter_ff) begin
         prior_mem[s1_idx_ff] <= rec;
      end
   end

   assign op_a    = left_ff[s1_slot_ff];
   assign op_c    = aleft_ff[s1_slot_ff];
   assign op_b    = s1_first_ff ? BYTE_W'(0) : prior_rd_ff;
   assign avg_sum = {1'b0, op_a} + {1'b0, op_b};

   always_comb begin
      case (s1_kind_ff)
         FILT_SUB:   pred = op_a;
         FILT_UP:    pred = op_b;
         FILT_AVG:   pred = avg_sum[BYTE_W:1];
         FILT_PAETH: pred = paeth_pred(op_a, op_b, op_c);
         default:    pred = BYTE_W'(0);
      endcase
   end

   assign rec = s1_byte_ff + pred;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            left_ff[k]  <= '0;
            aleft_ff[k] <= '0;
         end
      end else if (s1_adv) begin
         if (s1_filter_ff) begin
            for (int k = 0; k < 4; k++) begin
               left_ff[k]  <= '0;
               aleft_ff[k] <= '0;
            end
         end else begin
            left_ff[s1_slot_ff]  <= rec;
            aleft_ff[s1_slot_ff] <= op_b;
         end
      end
   end

   // result register
   always_comb begin
      if (s1_filter_ff) begin
         rsp_next.pixel_byte = '0;
         rsp_next.row_last   = 1'b0;
         rsp_next.bad_filter = 1'b1;
      end else begin
         rsp_next.pixel_byte = rec;
         rsp_next.row_last   = s1_last_ff;
         rsp_next.bad_filter = 1'b0;
      end
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

### tb/tb_png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// Testbench for png_scanline_unfilter
// Streams filter-type and data bytes through the unfilter and checks every
// rebuilt byte against a scoreboard that reconstructs the rows on its own.
// Covers all filter types, unknown types, pass starts, out-of-range register
// values, a row length change in the middle of a row and a row length register
// above the row buffer size. Both sides insert random gaps.
// ----------------------------------------------------------------------------
module tb_png_scanline_unfilter;
   import pngu_pkg::*;

   localparam int MAX_ROW      = 8192;
   localparam int SLOTS        = 4;
   localparam int MAX_GAP      = 14;
   localparam int RANDOM_BYTES = 1500;
   localparam int SETTLE       = 8;
   localparam int CYCLE_LIMIT  = 2_000_000;

   class unfilter_scoreboard;
      logic [BYTE_W-1:0] above_row [MAX_ROW];
      logic [BYTE_W-1:0] left_px [SLOTS];
      logic [BYTE_W-1:0] corner_px [SLOTS];
      logic [KIND_W-1:0] kind;
      logic [BPP_W-1:0]  bpp_reg;
      logic [ROWB_W-1:0] rowb_reg;
      int unsigned       pos;
      bit                first_row;
      int unsigned       reach;     // entries of above_row written so far
      rsp_payload_type   expected_pixels[$];
      int                mismatches;
      int                checked;
      int                rows;
      int                bad_rows;

      function new();
         kind      = FILT_NONE;
         bpp_reg   = BPP_W'(1);
         rowb_reg  = ROWB_W'(1);
         pos       = 0;
         first_row = 1'b1;
         reach     = 0;
         for (int s = 0; s < SLOTS; s++) begin
            left_px[s]   = '0;
            corner_px[s] = '0;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [ROWB_W-1:0] value);
         if (idx == CSR_BPP) bpp_reg = value[BPP_W-1:0];
         else if (idx == CSR_ROW_BYTES) rowb_reg = value;
      endfunction

      function int unsigned row_len();
         if (rowb_reg == 0) return 1;
         if (rowb_reg > MAX_ROW) return MAX_ROW;
         return 32'(rowb_reg);
      endfunction

      function int unsigned pixel_span();
         if (bpp_reg == 0) return 1;
         if (bpp_reg > SLOTS) return SLOTS;
         return 32'(bpp_reg);
      endfunction

      // a row that is not a pass start must only read bytes already written
      function bit needs_pass_start();
         return !first_row && row_len() > reach;
      endfunction

      function int waiting();
         return expected_pixels.size();
      endfunction

      function int paeth_pick(int a, int b, int c);
         int pa;
         int pb;
         int pc;
         pa = b - c;
         pb = a - c;
         pc = a + b - 2 * c;
         if (pa < 0) pa = -pa;
         if (pb < 0) pb = -pb;
         if (pc < 0) pc = -pc;
         if (pa <= pb && pa <= pc) return a;
         if (pb <= pc) return b;
         return c;
      endfunction

      function void note_stream_byte(req_payload_type p);
         int unsigned       i;
         int unsigned       slot;
         int                a;
         int                b;
         int                c;
         int                pred;
         logic [BYTE_W-1:0] rebuilt;
         bit                last;
         if (pos == 0) begin
            kind = (p.data_byte > FILT_PAETH) ? FILT_BAD : p.data_byte[KIND_W-1:0];
            if (p.new_pass) first_row = 1'b1;
            for (int s = 0; s < SLOTS; s++) begin
               left_px[s]   = '0;
               corner_px[s] = '0;
            end
            pos = 1;
            rows++;
            if (kind == FILT_BAD) begin
               bad_rows++;
               expected_pixels.push_back('{pixel_byte: '0, row_last: 1'b0,
                                           bad_filter: 1'b1});
            end
            return;
         end
         i    = pos - 1;
         slot = i % pixel_span();
         a    = int'(left_px[slot]);
         b    = first_row ? 0 : int'(above_row[i]);
         c    = int'(corner_px[slot]);
         case (kind)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = (a + b) >> 1;
            FILT_PAETH: pred = paeth_pick(a, b, c);
            default:    pred = 0;
         endcase
         rebuilt         = p.data_byte + pred[BYTE_W-1:0];
         above_row[i]    = rebuilt;
         left_px[slot]   = rebuilt;
         corner_px[slot] = b[BYTE_W-1:0];
         if (i + 1 > reach) reach = i + 1;
         last = (i + 1 >= row_len());
         if (last) begin
            pos       = 0;
            first_row = 1'b0;
         end else begin
            pos = i + 2;
         end
         expected_pixels.push_back('{pixel_byte: rebuilt, row_last: last,
                                     bad_filter: 1'b0});
      endfunction

      function void check_pixel(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_pixels.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result: byte %0d last %0b bad %0b",
                        got.pixel_byte, got.row_last, got.bad_filter);
            mismatches++;
            return;
         end
         want = expected_pixels.pop_front();
         checked++;
         if (got.pixel_byte !== want.pixel_byte || got.row_last !== want.row_last ||
             got.bad_filter !== want.bad_filter) begin
            if (mismatches < 10)
               $display("result %0d: expected byte %0d last %0b bad %0b, got byte %0d last %0b bad %0b",
                        checked, want.pixel_byte, want.row_last, want.bad_filter,
                        got.pixel_byte, got.row_last, got.bad_filter);
            mismatches++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_payload_type      req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_payload_type      rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_BPP;
   logic [ROWB_W-1:0]    csr_wdata = '0;

   unfilter_scoreboard sb = new();
   bit                 idle_on = 1'b1;
   int                 rsp_hold = 0;
   int                 bytes_sent = 0;
   int                 settings = 0;
   int                 cycles = 0;

   png_scanline_unfilter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("cycle limit reached with %0d results outstanding", sb.waiting());
         $display("png_scanline_unfilter: mismatch");
         $finish;
      end
   end

   function automatic int next_gap();
      return idle_on ? $urandom_range(MAX_GAP, 0) : 0;
   endfunction

   function automatic logic [BYTE_W-1:0] filter_code(logic [KIND_W-1:0] k);
      return {{(BYTE_W-KIND_W){1'b0}}, k};
   endfunction

   // result side: random stall after each accepted item
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_valid && rsp_ready) begin
         sb.check_pixel(rsp_payload);
         rsp_hold = next_gap();
         if (rsp_hold != 0) rsp_ready <= 1'b0;
      end else if (rsp_hold != 0) begin
         rsp_hold--;
         if (rsp_hold == 0) rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // valid stays high across back-to-back items, so it is only lowered for a gap
   task automatic push_byte(input logic [BYTE_W-1:0] value, input logic pass_start);
      int gap;
      gap = next_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: value, new_pass: pass_start};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_stream_byte(req_payload);
      bytes_sent++;
   endtask

   task automatic push_three(input logic [KIND_W-1:0] k, input logic pass_start,
                             input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
                             input logic [BYTE_W-1:0] b2);
      push_byte(filter_code(k), pass_start);
      push_byte(b0, 1'b0);
      push_byte(b1, 1'b1);
      push_byte(b2, 1'b0);
   endtask

   task automatic push_row(input logic [BYTE_W-1:0] code, input logic pass_start);
      int n;
      push_byte(code, pass_start);
      n = sb.row_len();
      repeat (n) push_byte(BYTE_W'($urandom_range(255, 0)), 1'($urandom_range(1, 0)));
   endtask

   task automatic random_row();
      logic [BYTE_W-1:0] code;
      logic              pass_start;
      if ($urandom_range(99, 0) < 12) code = BYTE_W'($urandom_range(255, FILT_BAD));
      else code = BYTE_W'($urandom_range(FILT_PAETH, FILT_NONE));
      pass_start = sb.needs_pass_start() ? 1'b1 : ($urandom_range(4, 0) == 0);
      push_row(code, pass_start);
   endtask

   // hold the input until every result is back, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.waiting() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic program_unfilter(input logic [ROWB_W-1:0] bpp_word,
                                   input logic [ROWB_W-1:0] rowb);
      csr_valid <= 1'b1;
      csr_index <= CSR_BPP;
      csr_wdata <= bpp_word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(CSR_BPP, bpp_word);
      csr_index <= CSR_ROW_BYTES;
      csr_wdata <= rowb;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(CSR_ROW_BYTES, rowb);
      csr_valid <= 1'b0;
      settings++;
   endtask

   initial begin
      logic [ROWB_W-1:0] bpp_word;
      logic [ROWB_W-1:0] rowb;
      int                random_start;
      int                rows_left;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: one byte per row, first row needs no pass flag
      push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b1);
      push_byte(filter_code(FILT_UP), 1'b0);
      push_byte(8'h01, 1'b0);
      drain();

      program_unfilter(ROWB_W'(1), ROWB_W'(3));
      push_three(FILT_NONE, 1'b1, 8'hFF, 8'h80, 8'h00);
      push_three(FILT_SUB, 1'b0, 8'hFF, 8'h01, 8'h00);
      push_three(FILT_AVG, 1'b0, 8'hFF, 8'hFF, 8'h07);
      push_three(FILT_PAETH, 1'b0, 8'h10, 8'hF0, 8'h7F);
      push_three(FILT_BAD, 1'b0, 8'h09, 8'hC8, 8'h03);
      drain();

      // shrink the row length while a row is open
      program_unfilter(ROWB_W'(7), ROWB_W'(6));
      push_byte(filter_code(FILT_SUB), 1'b1);
      push_byte(8'h55, 1'b0);
      push_byte(8'hAA, 1'b0);
      drain();
      program_unfilter(ROWB_W'(0), ROWB_W'(0));
      push_byte(8'h33, 1'b0);
      drain();

      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         idle_on  = ($urandom_range(3, 0) != 0);
         bpp_word = ROWB_W'($urandom_range((1 << ROWB_W) - 1, 0));
         if ($urandom_range(3, 0) != 0) bpp_word[ROWB_W-1:BPP_W] = '0;
         case ($urandom_range(9, 0))
            0:       rowb = ROWB_W'(0);
            1:       rowb = ROWB_W'(1);
            2:       rowb = ROWB_W'($urandom_range(300, 33));
            default: rowb = ROWB_W'($urandom_range(32, 2));
         endcase
         program_unfilter(bpp_word, rowb);
         rows_left = $urandom_range(6, 2);
         while (rows_left > 0 && bytes_sent - random_start < RANDOM_BYTES) begin
            random_row();
            rows_left--;
         end
         drain();
      end

      // row length register above the row buffer size, row closed by a short length
      idle_on = 1'b0;
      program_unfilter(ROWB_W'(3), '1);
      push_byte(filter_code(FILT_PAETH), 1'b1);
      repeat (SETTLE) push_byte(BYTE_W'($urandom_range(255, 0)), 1'b0);
      drain();
      program_unfilter(ROWB_W'(3), ROWB_W'(2));
      push_byte(BYTE_W'($urandom_range(255, 0)), 1'b0);
      drain();

      $display("sent %0d stream bytes in %0d rows (%0d with an unknown filter type)",
               bytes_sent, sb.rows, sb.bad_rows);
      $display("checked %0d results over %0d register settings",
               sb.checked, settings);
      if (sb.mismatches == 0 && sb.waiting() == 0) begin
         $display("png_scanline_unfilter: match");
      end else begin
         $display("png_scanline_unfilter: mismatch");
      end
      $finish;
   end

endmodule
